FILE: sv/nnd_pkg.sv
package nnd_pkg;

  // Fraction bits of the DIM_BITS.16 step ratios and accumulators
  localparam int unsigned FRAC_BITS = 16;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_GRAY_MODE  = 3'd4;

  localparam int unsigned PIX_W = 16;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIVX = 4'b0010,
    ST_DIVY = 4'b0100,
    ST_PIX  = 4'b1000
  } state_e;

  // Widen or pass the source pixel to RGB565, then swap its bytes
  function automatic logic [PIX_W-1:0] out_pixel(input logic [PIX_W-1:0] p,
                                                 input logic gray);
    logic [PIX_W-1:0] c;
    begin
      if (gray) begin
        c = {p[7:3], p[7:2], p[7:3]};
      end else begin
        c = p;
      end
      out_pixel = {c[7:0], c[15:8]};
    end
  endfunction

endpackage

FILE: sv/nearest_neighbor_downscaler_core.sv
// Nearest-neighbor downscaler for a raster pixel stream (RGB565 or 8-bit gray
// in the low byte of s_axis_tdata). A pixel flagged on s_axis_tuser starts a
// frame: the DIM_BITS.16 ratios (src << 16) / dst + 1 are then computed for
// both axes on one shared radix-2 divider, one quotient bit per cycle, so
// the next pixel waits until both divisions are done and that pixel has been
// stepped. Every other pixel is taken whenever the output register is free.
// Pixels before the first frame start are dropped. Results are RGB565 with the
// bytes swapped; tlast marks the end of a destination row and tuser the end
// of the destination frame. Destination sizes above the source are clamped,
// a size of zero counts as one. Configuration is written while the stream is
// idle; new ratios take effect at the next frame start.
module nearest_neighbor_downscaler_core #(
  parameter int unsigned DIM_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [nnd_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [DIM_BITS-1:0]             cfg_wdata_i,
  // source pixels
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,   // [15:0] pixel_value
  input  logic                            s_axis_tuser,   // [0] frame_start
  // destination pixels
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,   // [15:0] pixel_out
  output logic                            m_axis_tlast,   // row_end
  output logic                            m_axis_tuser    // [0] frame_end
);

  localparam int unsigned FB    = nnd_pkg::FRAC_BITS;
  localparam int unsigned ACC_W = DIM_BITS + FB;
  localparam int unsigned CNT_W = $clog2(ACC_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ACC_W - 1);

  // configuration registers
  logic [DIM_BITS-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic                gray_q;

  // scaling state
  logic [DIM_BITS-1:0] src_col_q, src_col_d, src_row_q, src_row_d;
  logic [DIM_BITS-1:0] dst_col_q, dst_col_d, dst_row_q, dst_row_d;
  logic [ACC_W-1:0]    x_acc_q, x_acc_d, y_acc_q, y_acc_d;
  logic [ACC_W-1:0]    x_step_q, x_step_d, y_step_q, y_step_d;

  nnd_pkg::state_e     state_q, state_d;
  logic [15:0]         pix_q, pix_d;

  // shared divider
  logic [ACC_W-1:0]    div_n_q, div_n_d;
  logic [DIM_BITS-1:0] div_d_q, div_d_d;
  logic [DIM_BITS-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [DIM_BITS:0]   trial, trial_sub;
  logic                trial_ge;
  logic [ACC_W-1:0]    quot, step_val;

  // output register
  logic                out_vld_q, out_vld_d;
  logic [15:0]         out_pix_q, out_pix_d;
  logic                out_re_q, out_re_d, out_fe_q, out_fe_d;

  // effective sizes
  logic [DIM_BITS-1:0] sw, sh, dw_raw, dh_raw, dw, dh;
  logic                out_free, accept, do_step;
  logic [15:0]         pix_sel;
  logic                row_hit, col_hit, row_end;

  assign sw     = (src_w_q == '0) ? DIM_BITS'(1) : src_w_q;
  assign sh     = (src_h_q == '0) ? DIM_BITS'(1) : src_h_q;
  assign dw_raw = (dst_w_q == '0) ? DIM_BITS'(1) : dst_w_q;
  assign dh_raw = (dst_h_q == '0) ? DIM_BITS'(1) : dst_h_q;
  assign dw     = (dw_raw > sw) ? sw : dw_raw;
  assign dh     = (dh_raw > sh) ? sh : dh_raw;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == nnd_pkg::ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // one restoring divide step per cycle
  assign trial     = {rem_q, div_n_q[ACC_W-1]};
  assign trial_ge  = trial >= {1'b0, div_d_q};
  assign trial_sub = trial - {1'b0, div_d_q};
  assign quot      = {div_n_q[ACC_W-2:0], trial_ge};
  assign step_val  = quot + ACC_W'(1);

  assign pix_sel = (state_q == nnd_pkg::ST_PIX) ? pix_q : s_axis_tdata;
  assign do_step = (accept && !s_axis_tuser && (x_step_q != '0)) ||
                   ((state_q == nnd_pkg::ST_PIX) && out_free);

  assign row_hit = (dst_row_q < dh) && (src_row_q == y_acc_q[ACC_W-1:FB]);
  assign col_hit = row_hit && (dst_col_q < dw) && (src_col_q == x_acc_q[ACC_W-1:FB]);
  assign row_end = dst_col_q == (dw - DIM_BITS'(1));

  always_comb begin
    state_d   = state_q;
    pix_d     = pix_q;
    div_n_d   = div_n_q;
    div_d_d   = div_d_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    x_step_d  = x_step_q;
    y_step_d  = y_step_q;
    src_col_d = src_col_q;
    src_row_d = src_row_q;
    dst_col_d = dst_col_q;
    dst_row_d = dst_row_q;
    x_acc_d   = x_acc_q;
    y_acc_d   = y_acc_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    out_pix_d = out_pix_q;
    out_re_d  = out_re_q;
    out_fe_d  = out_fe_q;

    case (state_q)
      nnd_pkg::ST_IDLE: begin
        if (accept && s_axis_tuser) begin
          // restart position, then work out the x ratio
          pix_d     = s_axis_tdata;
          src_col_d = '0;
          src_row_d = '0;
          dst_col_d = '0;
          dst_row_d = '0;
          x_acc_d   = '0;
          y_acc_d   = '0;
          div_n_d   = {sw, FB'(0)};
          div_d_d   = dw;
          rem_d     = '0;
          cnt_d     = '0;
          state_d   = nnd_pkg::ST_DIVX;
        end
      end
      nnd_pkg::ST_DIVX, nnd_pkg::ST_DIVY: begin
        div_n_d = quot;
        rem_d   = trial_ge ? trial_sub[DIM_BITS-1:0] : trial[DIM_BITS-1:0];
        cnt_d   = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          cnt_d = '0;
          rem_d = '0;
          if (state_q == nnd_pkg::ST_DIVX) begin
            x_step_d = step_val;
            div_n_d  = {sh, FB'(0)};
            div_d_d  = dh;
            state_d  = nnd_pkg::ST_DIVY;
          end else begin
            y_step_d = step_val;
            state_d  = nnd_pkg::ST_PIX;
          end
        end
      end
      nnd_pkg::ST_PIX: begin
        if (out_free) begin
          state_d = nnd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = nnd_pkg::ST_IDLE;
      end
    endcase

    if (do_step) begin
      if (col_hit) begin
        out_vld_d = 1'b1;
        out_pix_d = nnd_pkg::out_pixel(pix_sel, gray_q);
        out_re_d  = row_end;
        out_fe_d  = row_end && (dst_row_q == (dh - DIM_BITS'(1)));
        x_acc_d   = x_acc_q + x_step_q;
        dst_col_d = dst_col_q + DIM_BITS'(1);
      end
      if (({1'b0, src_col_q} + (DIM_BITS+1)'(1)) >= {1'b0, sw}) begin
        src_col_d = '0;
        x_acc_d   = '0;
        dst_col_d = '0;
        if (row_hit) begin
          y_acc_d   = y_acc_q + y_step_q;
          dst_row_d = dst_row_q + DIM_BITS'(1);
        end
        if (({1'b0, src_row_q} + (DIM_BITS+1)'(1)) >= {1'b0, sh}) begin
          src_row_d = '0;
          y_acc_d   = '0;
          dst_row_d = '0;
        end else begin
          src_row_d = src_row_q + DIM_BITS'(1);
        end
      end else begin
        src_col_d = src_col_q + DIM_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q   <= DIM_BITS'(320);
      src_h_q   <= DIM_BITS'(240);
      dst_w_q   <= DIM_BITS'(100);
      dst_h_q   <= DIM_BITS'(75);
      gray_q    <= 1'b0;
      state_q   <= nnd_pkg::ST_IDLE;
      cnt_q     <= '0;
      x_step_q  <= '0;
      y_step_q  <= '0;
      src_col_q <= '0;
      src_row_q <= '0;
      dst_col_q <= '0;
      dst_row_q <= '0;
      x_acc_q   <= '0;
      y_acc_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          nnd_pkg::CFG_SRC_WIDTH:  src_w_q <= cfg_wdata_i;
          nnd_pkg::CFG_SRC_HEIGHT: src_h_q <= cfg_wdata_i;
          nnd_pkg::CFG_DST_WIDTH:  dst_w_q <= cfg_wdata_i;
          nnd_pkg::CFG_DST_HEIGHT: dst_h_q <= cfg_wdata_i;
          nnd_pkg::CFG_GRAY_MODE:  gray_q  <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      x_step_q  <= x_step_d;
      y_step_q  <= y_step_d;
      src_col_q <= src_col_d;
      src_row_q <= src_row_d;
      dst_col_q <= dst_col_d;
      dst_row_q <= dst_row_d;
      x_acc_q   <= x_acc_d;
      y_acc_q   <= y_acc_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q     <= pix_d;
    div_n_q   <= div_n_d;
    div_d_q   <= div_d_d;
    rem_q     <= rem_d;
    out_pix_q <= out_pix_d;
    out_re_q  <= out_re_d;
    out_fe_q  <= out_fe_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_re_q;
  assign m_axis_tuser  = out_fe_q;

endmodule

FILE: sv/nnd_checker.sv
module nnd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_we_i,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [15:0]                     m_axis_tdata,
  input logic                            m_axis_tlast,
  input logic                            m_axis_tuser
);

  // frame end is always also a row end
  a_frame_end_is_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("frame end without row end");

  // ratio computation keeps the input closed for a while
  a_frame_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("item taken during ratio computation");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("stalled result changed");

  // configuration writes only land while no result is pending
  a_cfg_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !m_axis_tvalid)
    else $error("configuration written with a result pending");

endmodule

bind nearest_neighbor_downscaler_core nnd_checker u_nnd_checker (.*);

FILE: bench/tb_nearest_neighbor_downscaler_core.sv
module tb_nearest_neighbor_downscaler_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM = 12;
  localparam int ACC = DIM + nnd_pkg::FRAC_BITS;
  localparam int SETTLE_CYCLES = 80;     // covers the per-frame ratio division
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef logic [DIM-1:0] dim_t;
  typedef logic [ACC-1:0] acc_t;

  typedef struct packed {
    logic [15:0] pixel;
    logic        row_end;
    logic        frame_end;
  } dest_pixel_t;

  class downscale_scoreboard;
    dim_t src_w, src_h, dst_w, dst_h;
    logic gray;
    dim_t s_col, s_row, d_col, d_row;
    acc_t x_acc, y_acc, x_stp, y_stp;
    dest_pixel_t expected_px[$];
    int errors;

    function new();
      src_w = 320;
      src_h = 240;
      dst_w = 100;
      dst_h = 75;
      gray = 1'b0;
      s_col = '0;
      s_row = '0;
      d_col = '0;
      d_row = '0;
      x_acc = '0;
      y_acc = '0;
      x_stp = '0;
      y_stp = '0;
      errors = 0;
    endfunction

    function dim_t at_least_one(dim_t v);
      return (v == '0) ? dim_t'(1) : v;
    endfunction

    // clamp the destination size to the source size
    function dim_t dest_size(dim_t d, dim_t s);
      dim_t se, de;
      se = at_least_one(s);
      de = at_least_one(d);
      return (de > se) ? se : de;
    endfunction

    function acc_t step_ratio(dim_t s, dim_t d);
      logic [31:0] num;
      num = 32'(at_least_one(s)) << nnd_pkg::FRAC_BITS;
      return acc_t'(num / 32'(d) + 32'd1);
    endfunction

    function void set_register(logic [nnd_pkg::CFG_ADDR_W-1:0] idx, dim_t val);
      case (idx)
        nnd_pkg::CFG_SRC_WIDTH:  src_w = val;
        nnd_pkg::CFG_SRC_HEIGHT: src_h = val;
        nnd_pkg::CFG_DST_WIDTH:  dst_w = val;
        nnd_pkg::CFG_DST_HEIGHT: dst_h = val;
        nnd_pkg::CFG_GRAY_MODE:  gray = val[0];
        default: ;
      endcase
    endfunction

    function void take_source_pixel(logic [15:0] pix, logic fs);
      dim_t sw, sh, dw, dh;
      logic [15:0] g, c;
      logic row_hit;
      dest_pixel_t e;
      sw = at_least_one(src_w);
      sh = at_least_one(src_h);
      dw = dest_size(dst_w, src_w);
      dh = dest_size(dst_h, src_h);
      if (fs) begin
        x_stp = step_ratio(src_w, dw);
        y_stp = step_ratio(src_h, dh);
        s_col = '0;
        s_row = '0;
        x_acc = '0;
        y_acc = '0;
        d_col = '0;
        d_row = '0;
      end
      // drop pixels until a frame has been started
      if (x_stp == '0) return;
      row_hit = (d_row < dh) && (s_row == y_acc[ACC-1:nnd_pkg::FRAC_BITS]);
      if (row_hit && d_col < dw && s_col == x_acc[ACC-1:nnd_pkg::FRAC_BITS]) begin
        if (gray) begin
          g = {8'd0, pix[7:0]};
          c = ((g >> 3) << 11) | ((g >> 2) << 5) | (g >> 3);
        end else begin
          c = pix;
        end
        e.pixel = {c[7:0], c[15:8]};
        e.row_end = (d_col == dw - dim_t'(1));
        e.frame_end = e.row_end && (d_row == dh - dim_t'(1));
        expected_px.push_back(e);
        x_acc = x_acc + x_stp;
        d_col = d_col + dim_t'(1);
      end
      if (int'(s_col) + 1 >= int'(sw)) begin
        s_col = '0;
        x_acc = '0;
        d_col = '0;
        if (row_hit) begin
          y_acc = y_acc + y_stp;
          d_row = d_row + dim_t'(1);
        end
        if (int'(s_row) + 1 >= int'(sh)) begin
          s_row = '0;
          y_acc = '0;
          d_row = '0;
        end else begin
          s_row = s_row + dim_t'(1);
        end
      end else begin
        s_col = s_col + dim_t'(1);
      end
    endfunction

    function void check_dest_pixel(logic [15:0] pix, logic re, logic fe);
      dest_pixel_t e;
      if (expected_px.size() == 0) begin
        $display("%0t: unexpected pixel %h row_end %b frame_end %b", $time, pix, re, fe);
        errors++;
        return;
      end
      e = expected_px.pop_front();
      if (pix !== e.pixel) begin
        $display("%0t: pixel_out expected %h got %h", $time, e.pixel, pix);
        errors++;
      end
      if (re !== e.row_end) begin
        $display("%0t: row_end expected %b got %b", $time, e.row_end, re);
        errors++;
      end
      if (fe !== e.frame_end) begin
        $display("%0t: frame_end expected %b got %b", $time, e.frame_end, fe);
        errors++;
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [nnd_pkg::CFG_ADDR_W-1:0] cfg_addr_i;
  dim_t                           cfg_wdata_i;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [15:0]                    s_axis_tdata;
  logic                           s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [15:0]                    m_axis_tdata;
  logic                           m_axis_tlast;
  logic                           m_axis_tuser;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;

  downscale_scoreboard sb;

  nearest_neighbor_downscaler_core #(
    .DIM_BITS(DIM)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.take_source_pixel(s_axis_tdata, s_axis_tuser);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_dest_pixel(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("nearest_neighbor_downscaler_core: mismatch");
    $finish;
  end

  // sink side: random stalls, plus one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_pixel(input logic [15:0] pix, input logic fs);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = pix;
    s_axis_tuser = fs;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(input logic [nnd_pkg::CFG_ADDR_W-1:0] idx, input dim_t val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_addr_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_register(idx, val);
  endtask

  // write all registers once the stream has drained and the divider is quiet
  task automatic configure(input dim_t sw, input dim_t sh, input dim_t dw, input dim_t dh,
                           input logic gray);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.expected_px.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    write_reg(nnd_pkg::CFG_SRC_WIDTH, sw);
    write_reg(nnd_pkg::CFG_SRC_HEIGHT, sh);
    write_reg(nnd_pkg::CFG_DST_WIDTH, dw);
    write_reg(nnd_pkg::CFG_DST_HEIGHT, dh);
    write_reg(nnd_pkg::CFG_GRAY_MODE, dim_t'(gray));
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
      default: begin send_idle_pct = 14; recv_stall_pct = 14; end
    endcase
  endtask

  // mostly whole frames with random pixels; some continue without a frame
  // start, some are cut short with stray frame starts
  task automatic random_frames(input dim_t sw, input dim_t sh, input int budget);
    int sent, kind, len, full;
    logic fs;
    full = ((sw == 0) ? 1 : int'(sw)) * ((sh == 0) ? 1 : int'(sh));
    if (full > 150) full = 150;
    sent = 0;
    while (sent < budget) begin
      kind = $urandom_range(0, 99);
      len = (full > budget - sent) ? budget - sent : full;
      if (kind >= 90) len = $urandom_range(1, len);
      for (int k = 0; k < len; k++) begin
        if (kind < 80) fs = (k == 0);
        else if (kind < 90) fs = 1'b0;
        else fs = ($urandom_range(0, 4) == 0);
        send_pixel(16'($urandom_range(0, 65535)), fs);
      end
      sent += len;
    end
  endtask

  initial begin
    dim_t sw, sh, dw, dh;
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = nnd_pkg::CFG_SRC_WIDTH;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset sizes; pixels ahead of the first frame start are dropped
    set_idling(0);
    send_pixel(16'h1111, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h5A5A, 1'b0);
    send_pixel(16'hA5A5, 1'b0);
    send_pixel(16'h00FF, 1'b0);
    send_pixel(16'hFF00, 1'b0);
    send_pixel(16'h8001, 1'b0);

    // equal sizes in gray, then run past the end of the frame
    configure(3, 2, 3, 2, 1'b1);
    send_pixel(16'h00FF, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFF80, 1'b0);
    send_pixel(16'h007F, 1'b0);
    send_pixel(16'h1208, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h00F8, 1'b0);
    send_pixel(16'h0001, 1'b0);

    // zero sizes count as one, a wider destination is clamped
    configure(0, 2, 5, 0, 1'b0);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h1234, 1'b0);

    for (int p = 0; p < 13; p++) begin
      case (p)
        0: begin sw = 4095; sh = 4095; dw = 4095; dh = 4095; end
        1: begin sw = 4095; sh = 1;    dw = 1;    dh = 4095; end
        2: begin sw = 1;    sh = 4095; dw = 1;    dh = 4095; end
        default: begin
          sw = dim_t'($urandom_range(0, 12));
          sh = dim_t'($urandom_range(0, 8));
          dw = dim_t'($urandom_range(0, int'(sw) + 2));
          dh = dim_t'($urandom_range(0, int'(sh) + 2));
        end
      endcase
      configure(sw, sh, dw, dh, 1'(p == 0 ? 1 : $urandom_range(0, 1)));
      set_idling(p % 4);
      // hold the sink off while the source keeps offering pixels
      if (p == 4) hold_req = 1'b1;
      random_frames(sw, sh, (p < 3) ? 80 : 130);
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.expected_px.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_px.size() == 0) begin
      $display("nearest_neighbor_downscaler_core: match");
    end else begin
      $display("nearest_neighbor_downscaler_core: mismatch");
    end
    $finish;
  end

endmodule
